/* src/pps_pkg.sv */
// ============================================================================
// pps_pkg
// Shared types, codes and helpers of the preemptive priority scheduler.
// ============================================================================
package pps_pkg;

    // Operation codes of an input item
    localparam logic OP_ADMIT = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    // Last-run marker: 0..255 a tag, RUN_IDLE idle, RUN_NONE after reset
    localparam logic [8:0] RUN_IDLE = 9'h100;
    localparam logic [8:0] RUN_NONE = 9'h1FF;

    localparam logic [31:0] TIME_MAX = 32'hFFFF_FFFF;

    // One input item
    typedef struct packed {
        logic        op;
        logic [7:0]  task_tag;
        logic [7:0]  task_priority;
        logic [15:0] burst_length;
    } pps_item_t;

    // One result item
    typedef struct packed {
        logic        admit_error;
        logic        idle;
        logic [7:0]  run_tag;
        logic        segment_start;
        logic        finished;
        logic [31:0] now_time;
        logic [31:0] exit_time;
        logic [31:0] turnaround;
        logic [31:0] wait_time;
    } pps_result_t;

    // Contents of one task slot
    typedef struct packed {
        logic [7:0]  tag;
        logic [7:0]  priority_num;
        logic [15:0] remaining;
        logic [15:0] burst;
        logic [31:0] arrival;
        logic [31:0] sequence_num;
    } slot_entry_t;

    // Saturating increment of a 32-bit counter
    function automatic logic [31:0] sat_inc(input logic [31:0] x);
        sat_inc = (x == TIME_MAX) ? x : x + 32'd1;
    endfunction

endpackage

/* src/pps_stream_if.sv */
// ============================================================================
// pps_stream_if
// Valid/ready channel carrying one item of payload type T.
// ============================================================================
interface pps_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* src/pps_select.sv */
// ============================================================================
// pps_select
// Picks the running task through a min tree over the slots and finds the
// lowest free slot.
// ============================================================================
module pps_select
    import pps_pkg::*;
#(
    parameter int TASK_SLOTS = 8
) (
    input  logic                               slot_valid [TASK_SLOTS],
    input  slot_entry_t                        slot_entry [TASK_SLOTS],
    output logic                               best_valid,
    output logic [$clog2(TASK_SLOTS)-1:0]      best_idx,
    output slot_entry_t                        best_entry,
    output logic                               free_found,
    output logic [$clog2(TASK_SLOTS)-1:0]      free_idx
);

    localparam int IDX_W = $clog2(TASK_SLOTS);
    localparam int P2    = 1 << IDX_W;

    typedef struct packed {
        logic             valid;
        logic [IDX_W-1:0] idx;
        slot_entry_t      entry;
    } node_t;

    node_t node [1:2*P2-1];

    // Right side wins only when strictly better: equal keys keep lower slot
    function automatic node_t pick(input node_t a, input node_t b);
        logic take_b;
        take_b = b.valid && (!a.valid ||
                 (b.entry.priority_num < a.entry.priority_num) ||
                 ((b.entry.priority_num == a.entry.priority_num) &&
                  (b.entry.sequence_num < a.entry.sequence_num)));
        pick = take_b ? b : a;
    endfunction

    // Leaves, padded with empty ones up to a power of two
    for (genvar g = 0; g < P2; g++) begin : g_leaf
        if (g < TASK_SLOTS) begin : g_used
            assign node[P2+g] = '{valid: slot_valid[g], idx: IDX_W'(g),
                                  entry: slot_entry[g]};
        end else begin : g_pad
            assign node[P2+g] = '{valid: 1'b0, idx: IDX_W'(g), entry: '0};
        end
    end

    // Comparison nodes
    for (genvar n = 1; n < P2; n++) begin : g_node
        assign node[n] = pick(node[2*n], node[2*n+1]);
    end

    assign best_valid = node[1].valid;
    assign best_idx   = node[1].idx;
    assign best_entry = node[1].entry;

    // Lowest free slot
    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = TASK_SLOTS - 1; i >= 0; i--)
        begin
            if (!slot_valid[i])
            begin
                free_found = 1'b1;
                free_idx   = IDX_W'(i);
            end
        end
    end

endmodule

/* src/preemptive_priority_scheduler.sv */
// ============================================================================
// preemptive_priority_scheduler
// Table of ready tasks served by preemptive priority, one tick at a time.
// ============================================================================
// Every item, admit or tick, gives exactly one result. Items are taken into
// an input register and worked there combinationally: the lowest priority
// number among valid slots (earliest admitted on a tie, then lowest slot) is
// found by a comparison tree of log2(TASK_SLOTS) levels, and the slot table,
// time and admission counters are updated at the same edge the result
// register loads. The block takes one item per clock when the result side is
// ready; each result is held in the result register, after the input
// register, until it is taken. The table holds TASK_SLOTS tasks; admits to a
// full table or with a zero burst are flagged.
module preemptive_priority_scheduler
    import pps_pkg::*;
#(
    parameter int TASK_SLOTS = 8
) (
    input  logic                        clk,
    input  logic                        rst_n,
    pps_stream_if.sink                  request,
    pps_stream_if.source                result
);

    localparam int IDX_W = $clog2(TASK_SLOTS);
    localparam int CNT_W = $clog2(TASK_SLOTS + 1);

    // Input stage
    pps_item_t   in_reg;
    logic        in_valid_reg;
    // Result stage
    pps_result_t out_reg;
    logic        out_valid_reg;
    // Scheduler state
    logic        slot_valid_reg [TASK_SLOTS];
    slot_entry_t slot_reg       [TASK_SLOTS];
    logic [31:0] time_reg;
    logic [31:0] admit_cnt_reg;
    logic [8:0]  last_run_reg;

    logic             fire;
    logic             best_valid;
    logic [IDX_W-1:0] best_idx;
    slot_entry_t      best_entry;
    logic             free_found;
    logic [IDX_W-1:0] free_idx;

    pps_result_t res_next;
    logic        do_store;
    logic        do_run;
    logic        do_free;
    logic [15:0] rem_dec;
    logic [31:0] time_inc;
    logic [31:0] ta_val;
    logic [8:0]  last_run_next;

    // Handshake
    assign fire          = in_valid_reg && (!out_valid_reg || result.ready);
    assign request.ready = !in_valid_reg || fire;
    assign result.valid  = out_valid_reg;
    assign result.data   = out_reg;

    pps_select #(
        .TASK_SLOTS (TASK_SLOTS)
    ) u_select (
        .slot_valid (slot_valid_reg),
        .slot_entry (slot_reg),
        .best_valid (best_valid),
        .best_idx   (best_idx),
        .best_entry (best_entry),
        .free_found (free_found),
        .free_idx   (free_idx)
    );

    // Work for the item in the input register
    always_comb
    begin
        res_next          = '0;
        res_next.now_time = time_reg;
        do_store          = 1'b0;
        do_run            = 1'b0;
        do_free           = 1'b0;
        rem_dec           = best_entry.remaining - 16'd1;
        time_inc          = sat_inc(time_reg);
        ta_val            = time_inc - best_entry.arrival;
        last_run_next     = last_run_reg;
        unique case (in_reg.op)
            OP_ADMIT:
            begin
                if ((in_reg.burst_length == 16'd0) || !free_found)
                    res_next.admit_error = 1'b1;
                else
                    do_store = 1'b1;
            end
            OP_TICK:
            begin
                if (!best_valid)
                begin
                    res_next.idle          = 1'b1;
                    res_next.segment_start = (last_run_reg != RUN_IDLE);
                    last_run_next          = RUN_IDLE;
                end
                else
                begin
                    do_run                 = 1'b1;
                    res_next.run_tag       = best_entry.tag;
                    res_next.segment_start = (last_run_reg != {1'b0, best_entry.tag});
                    last_run_next          = {1'b0, best_entry.tag};
                    if (rem_dec == 16'd0)
                    begin
                        do_free             = 1'b1;
                        res_next.finished   = 1'b1;
                        res_next.exit_time  = time_inc;
                        res_next.turnaround = ta_val;
                        res_next.wait_time  = (ta_val >= {16'd0, best_entry.burst}) ?
                                              ta_val - {16'd0, best_entry.burst} : 32'd0;
                    end
                end
            end
            default: ;
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            time_reg      <= '0;
            admit_cnt_reg <= '0;
            last_run_reg  <= RUN_NONE;
            for (int i = 0; i < TASK_SLOTS; i++)
                slot_valid_reg[i] <= 1'b0;
        end
        else
        begin
            if (request.ready)
                in_valid_reg <= request.valid;
            if (fire)
                out_valid_reg <= 1'b1;
            else if (result.ready)
                out_valid_reg <= 1'b0;
            if (fire)
            begin
                if (in_reg.op == OP_TICK)
                begin
                    time_reg     <= time_inc;
                    last_run_reg <= last_run_next;
                end
                if (do_store)
                begin
                    slot_valid_reg[free_idx] <= 1'b1;
                    admit_cnt_reg            <= sat_inc(admit_cnt_reg);
                end
                if (do_free)
                    slot_valid_reg[best_idx] <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (request.ready && request.valid)
            in_reg <= request.data;
        if (fire)
        begin
            out_reg <= res_next;
            if (do_store)
                slot_reg[free_idx] <= '{tag:          in_reg.task_tag,
                                        priority_num: in_reg.task_priority,
                                        remaining:    in_reg.burst_length,
                                        burst:        in_reg.burst_length,
                                        arrival:      time_reg,
                                        sequence_num: admit_cnt_reg};
            if (do_run)
                slot_reg[best_idx].remaining <= rem_dec;
        end
    end

    // Occupancy count, for checking only
    logic [CNT_W-1:0] occupancy;
    always_comb
    begin
        occupancy = '0;
        for (int i = 0; i < TASK_SLOTS; i++)
            occupancy = occupancy + CNT_W'(slot_valid_reg[i]);
    end

    // Time moves by at most one per cycle and never backwards
    a_time_step: assert property (@(posedge clk) disable iff (!rst_n)
        (time_reg == $past(time_reg)) || (time_reg == $past(time_reg) + 32'd1))
        else $error("time counter jumped");

    // A successful admit fills exactly one slot
    a_admit_fills: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && do_store) |=> (occupancy == $past(occupancy) + CNT_W'(1)))
        else $error("admit did not fill one slot");

    // A finished task's slot is freed
    a_finish_frees: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && do_free) |=> !slot_valid_reg[$past(best_idx)])
        else $error("finished task still holds its slot");

    // An idle result never also carries the finished or admit_error flag
    a_tick_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_reg.idle && (out_reg.finished || out_reg.admit_error)))
        else $error("inconsistent result flags");

endmodule
